// File: hdl/hwt_pkg.sv
package hwt_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned TIMEOUT_W = 32;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned OVER_W    = 32;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_REGISTER  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_HEARTBEAT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CHECK     = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ISSUE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

  // Configuration register map.
  localparam int unsigned        CFG_ADDR_W          = 3;
  localparam logic               CFG_IDX_DEFAULT_TMO = 1'b0;
  localparam logic [TIMEOUT_W-1:0] DEFAULT_TMO_RST   = 32'd5000;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } hwt_state_e;

  // Write strobes from the controller to the slot table.
  typedef struct packed {
    logic beat_we;
    logic tmo_we;
  } hwt_wr_t;

endpackage

// File: hdl/heartbeat_watchdog_table_top.sv
// Heartbeat watchdog over a table of slots.
// Requests enter on in_valid_i/in_stall_o with func_i, slot_i and timeout_ms_i:
// register, remove, heartbeat, tick one millisecond, or check all slots.
// Results leave on out_valid_o/out_stall_i; every request ends with a result
// that has last_result_o set.
// Register, remove, heartbeat, tick and unknown codes are handled in the cycle
// of acceptance; their acknowledge is valid on the next cycle, and a new request
// can be taken every cycle while results drain.
// A check walks the table through the registered memory read port, one slot
// per cycle unless it pauses for a stalled receiver; no new request is taken
// during the walk.
// When out_stall_i is high the result register holds and the walk pauses at an
// overdue slot until the waiting issue is taken.
// The default timeout is written through the APB port at byte address 0.
// Reset clears all slot and stale marks, the millisecond counter and the
// default timeout to 5000; the timestamp and timeout memories are not cleared.
module heartbeat_watchdog_table_top import hwt_pkg::*; #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [TIMEOUT_W-1:0]  timeout_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     kind_o,
  output logic [SLOT_W-1:0]     out_slot_o,
  output logic [OVER_W-1:0]     overdue_ms_o,
  output logic                  newly_stale_o,
  output logic                  recovered_o,
  output logic                  last_result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [TIMEOUT_W-1:0] default_tmo_q;
  hwt_wr_t              wr;
  logic [IW-1:0]        wr_addr;
  logic [TIME_BITS-1:0] wr_beat;
  logic [TIMEOUT_W-1:0] wr_tmo;
  logic [IW-1:0]        rd_addr;
  logic [TIME_BITS-1:0] rd_beat;
  logic [TIMEOUT_W-1:0] rd_tmo;

  // Configuration register write and read.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_DEFAULT_TMO) ? default_tmo_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_tmo_q <= DEFAULT_TMO_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_DEFAULT_TMO) begin
      default_tmo_q <= pwdata;
    end
  end

  hwt_ctrl #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS),
    .IW        (IW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .slot_i        (slot_i),
    .timeout_ms_i  (timeout_ms_i),
    .default_tmo_i (default_tmo_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_slot_o    (out_slot_o),
    .overdue_ms_o  (overdue_ms_o),
    .newly_stale_o (newly_stale_o),
    .recovered_o   (recovered_o),
    .last_result_o (last_result_o),
    .wr_o          (wr),
    .wr_addr_o     (wr_addr),
    .wr_beat_o     (wr_beat),
    .wr_tmo_o      (wr_tmo),
    .rd_addr_o     (rd_addr),
    .rd_beat_i     (rd_beat),
    .rd_tmo_i      (rd_tmo)
  );

  hwt_table #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS),
    .IW        (IW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .wr_beat_i (wr_beat),
    .wr_tmo_i  (wr_tmo),
    .rd_addr_i (rd_addr),
    .rd_beat_o (rd_beat),
    .rd_tmo_o  (rd_tmo)
  );

endmodule

// File: hdl/hwt_table.sv
module hwt_table import hwt_pkg::*; #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned IW        = 4
) (
  input  logic                 clk_i,
  input  hwt_wr_t              wr_i,
  input  logic [IW-1:0]        wr_addr_i,
  input  logic [TIME_BITS-1:0] wr_beat_i,
  input  logic [TIMEOUT_W-1:0] wr_tmo_i,
  input  logic [IW-1:0]        rd_addr_i,
  output logic [TIME_BITS-1:0] rd_beat_o,
  output logic [TIMEOUT_W-1:0] rd_tmo_o
);

  logic [TIME_BITS-1:0] beat_mem [SLOTS];
  logic [TIMEOUT_W-1:0] tmo_mem  [SLOTS];

  // Last heartbeat time per slot, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.beat_we) begin
      beat_mem[wr_addr_i] <= wr_beat_i;
    end
    rd_beat_o <= beat_mem[rd_addr_i];
  end

  // Timeout per slot, written separately so a heartbeat on an armed slot keeps it.
  always_ff @(posedge clk_i) begin
    if (wr_i.tmo_we) begin
      tmo_mem[wr_addr_i] <= wr_tmo_i;
    end
    rd_tmo_o <= tmo_mem[rd_addr_i];
  end

endmodule

// File: hdl/hwt_ctrl.sv
module hwt_ctrl import hwt_pkg::*; #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned IW        = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [TIMEOUT_W-1:0] timeout_ms_i,
  input  logic [TIMEOUT_W-1:0] default_tmo_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [KIND_W-1:0]    kind_o,
  output logic [SLOT_W-1:0]    out_slot_o,
  output logic [OVER_W-1:0]    overdue_ms_o,
  output logic                 newly_stale_o,
  output logic                 recovered_o,
  output logic                 last_result_o,
  output hwt_wr_t              wr_o,
  output logic [IW-1:0]        wr_addr_o,
  output logic [TIME_BITS-1:0] wr_beat_o,
  output logic [TIMEOUT_W-1:0] wr_tmo_o,
  output logic [IW-1:0]        rd_addr_o,
  input  logic [TIME_BITS-1:0] rd_beat_i,
  input  logic [TIMEOUT_W-1:0] rd_tmo_i
);

  // Width for elapsed and overdue arithmetic; always has bits above 31.
  localparam int unsigned EW = (TIME_BITS > 32) ? TIME_BITS : 33;
  localparam int unsigned SW = 9;
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  hwt_state_e state_q, state_d;

  logic [SLOTS-1:0]     valid_q, valid_d;
  logic [SLOTS-1:0]     stale_q, stale_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [IW-1:0]        idx_q, idx_d;

  logic                 pend_valid_q, pend_valid_d;
  logic [SLOT_W-1:0]    pend_slot_q, pend_slot_d;
  logic [OVER_W-1:0]    pend_over_q, pend_over_d;
  logic                 pend_new_q, pend_new_d;

  logic                 out_valid_q, out_valid_d;
  logic [KIND_W-1:0]    o_kind_q, o_kind_d;
  logic [SLOT_W-1:0]    o_slot_q, o_slot_d;
  logic [OVER_W-1:0]    o_over_q, o_over_d;
  logic                 o_new_q, o_new_d;
  logic                 o_rec_q, o_rec_d;
  logic                 o_last_q, o_last_d;
  logic                 out_load;

  logic                 acc;
  logic                 out_free;
  logic                 in_range;
  logic [IW+SLOT_W-1:0] slot_ext;
  logic [IW-1:0]        sidx;
  logic [IW+SLOT_W-1:0] idx_ext;
  logic [SLOT_W-1:0]    idx_slot;

  logic [TIME_BITS-1:0] elapsed;
  logic [EW-1:0]        over_full;
  logic [OVER_W-1:0]    over_sat;
  logic                 hit;
  logic                 advance;
  logic                 idx_last;

  // Request handshake: take a request only when idle and the result slot is free.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign acc        = in_valid_i && !in_stall_o;

  // Slot index of the request and of the walk, resized to the table index.
  assign slot_ext = {{IW{1'b0}}, slot_i};
  assign sidx     = slot_ext[IW-1:0];
  assign in_range = (SW'(slot_i) < SW'(SLOTS));
  assign idx_ext  = {{SLOT_W{1'b0}}, idx_q};
  assign idx_slot = idx_ext[SLOT_W-1:0];
  assign idx_last = (idx_q == IDX_LAST);

  // Overdue test on the entry read in the previous cycle.
  assign elapsed   = time_q - rd_beat_i;
  assign over_full = EW'(elapsed) - EW'(rd_tmo_i);
  assign over_sat  = (|over_full[EW-1:OVER_W]) ? {OVER_W{1'b1}} : over_full[OVER_W-1:0];
  assign hit       = valid_q[idx_q] && (EW'(elapsed) > EW'(rd_tmo_i));
  assign advance   = !(hit && pend_valid_q && !out_free);

  // Table write port: heartbeat time is the current time; timeout by request.
  assign wr_addr_o = sidx;
  assign wr_beat_o = time_q;
  assign wr_tmo_o  = (func_i == FUNC_REGISTER && timeout_ms_i != '0) ? timeout_ms_i
                                                                       : default_tmo_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && func_i == FUNC_CHECK) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (advance && idx_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and table updates per state.
  always_comb begin
    out_load     = 1'b0;
    o_kind_d     = KIND_ACK;
    o_slot_d     = slot_i;
    o_over_d     = '0;
    o_new_d      = 1'b0;
    o_rec_d      = 1'b0;
    o_last_d     = 1'b1;
    valid_d      = valid_q;
    stale_d      = stale_q;
    time_d       = time_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_over_d  = pend_over_q;
    pend_new_d   = pend_new_q;
    wr_o         = '0;
    rd_addr_o    = idx_q;
    case (state_q)
      ST_IDLE: begin
        idx_d        = '0;
        rd_addr_o    = '0;
        pend_valid_d = 1'b0;
        if (acc) begin
          out_load = 1'b1;
          case (func_i)
            FUNC_REGISTER: begin
              if (in_range) begin
                valid_d[sidx] = 1'b1;
                stale_d[sidx] = 1'b0;
                wr_o.beat_we  = 1'b1;
                wr_o.tmo_we   = 1'b1;
              end
            end
            FUNC_REMOVE: begin
              if (in_range) begin
                valid_d[sidx] = 1'b0;
                stale_d[sidx] = 1'b0;
              end
            end
            FUNC_HEARTBEAT: begin
              if (in_range) begin
                if (!valid_q[sidx]) begin
                  valid_d[sidx] = 1'b1;
                  wr_o.tmo_we   = 1'b1;
                end else begin
                  o_rec_d = stale_q[sidx];
                end
                stale_d[sidx] = 1'b0;
                wr_o.beat_we  = 1'b1;
              end
            end
            FUNC_TICK: begin
              time_d   = time_q + 1'b1;
              o_slot_d = '0;
            end
            FUNC_CHECK: begin
              out_load = 1'b0;
            end
            default: begin
              o_slot_d = '0;
            end
          endcase
        end
      end
      ST_WALK: begin
        // An issue is held back one step so the final one can carry last_result.
        if (hit && advance) begin
          if (pend_valid_q) begin
            out_load = 1'b1;
            o_kind_d = KIND_ISSUE;
            o_slot_d = pend_slot_q;
            o_over_d = pend_over_q;
            o_new_d  = pend_new_q;
            o_last_d = 1'b0;
          end
          pend_valid_d   = 1'b1;
          pend_slot_d    = idx_slot;
          pend_over_d    = over_sat;
          pend_new_d     = !stale_q[idx_q];
          stale_d[idx_q] = 1'b1;
        end
        if (advance && !idx_last) begin
          idx_d     = idx_q + 1'b1;
          rd_addr_o = idx_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          pend_valid_d = 1'b0;
          if (pend_valid_q) begin
            o_kind_d = KIND_ISSUE;
            o_slot_d = pend_slot_q;
            o_over_d = pend_over_q;
            o_new_d  = pend_new_q;
          end else begin
            o_kind_d = KIND_NONE;
            o_slot_d = '0;
          end
        end
      end
      default: begin
        pend_valid_d = 1'b0;
      end
    endcase
  end

  // Result register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      stale_q      <= '0;
      time_q       <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      stale_q      <= stale_d;
      time_q       <= time_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    pend_over_q <= pend_over_d;
    pend_new_q  <= pend_new_d;
    if (out_load) begin
      o_kind_q <= o_kind_d;
      o_slot_q <= o_slot_d;
      o_over_q <= o_over_d;
      o_new_q  <= o_new_d;
      o_rec_q  <= o_rec_d;
      o_last_q <= o_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = o_kind_q;
  assign out_slot_o    = o_slot_q;
  assign overdue_ms_o  = o_over_q;
  assign newly_stale_o = o_new_q;
  assign recovered_o   = o_rec_q;
  assign last_result_o = o_last_q;

  // A slot can only be marked stale while it is armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (stale_q & ~valid_q) == '0)
    else $error("stale mark on an empty slot");

  // A held issue exists only during a check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q != ST_IDLE))
    else $error("held issue outside a check");

  // The walk never leaves the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (SW'(idx_q) < SW'(SLOTS)))
    else $error("walk index beyond the table");

  // A none result closes its check and carries no overdue amount.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_kind_q == KIND_NONE) |-> (o_last_q && o_over_q == '0 && !o_new_q))
    else $error("malformed none result");

  // Finishing a check always delivers a closing result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> (out_valid_q && o_last_q && state_q == ST_IDLE))
    else $error("check ended without a final result");

endmodule
